### rtl/cvsg_pkg.sv
package cvsg_pkg;

    localparam int unsigned TICK_W = 6;
    localparam int unsigned LINE_W = 9;
    localparam int unsigned PULSE_W = 3;
    localparam int unsigned LUMA_W = 8;
    localparam int unsigned LEVEL_W = 3;
    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [PULSE_W-1:0] EQ_BASE_PULSES = 3'd5;
    localparam logic [LINE_W-1:0] MAX_LINES = 9'd312;

    localparam logic [LEVEL_W-1:0] LEVEL_SYNC = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_BLANK = 3'd1;

    typedef enum logic [1:0] {
        PHASE_PRE_EQ  = 2'd0,
        PHASE_BROAD   = 2'd1,
        PHASE_POST_EQ = 2'd2,
        PHASE_LINES   = 2'd3
    } phase_t;

    // In the pulse phases only SEG_LOW and SEG_HIGH are used.
    typedef enum logic [1:0] {
        SEG_LOW    = 2'd0,
        SEG_HIGH   = 2'd1,
        SEG_ACTIVE = 2'd2,
        SEG_FRONT  = 2'd3
    } seg_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHORT_LOW   = 3'd0,
        REG_SHORT_HIGH  = 3'd1,
        REG_BROAD_LOW   = 3'd2,
        REG_BROAD_HIGH  = 3'd3,
        REG_LINE_SYNC   = 3'd4,
        REG_BACK_PORCH  = 3'd5,
        REG_FRONT_PORCH = 3'd6,
        REG_LINES       = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0] short_low;
        logic [TICK_W-1:0] short_high;
        logic [TICK_W-1:0] broad_low;
        logic [TICK_W-1:0] broad_high;
        logic [TICK_W-1:0] line_sync;
        logic [TICK_W-1:0] back_porch;
        logic [TICK_W-1:0] front_porch;
        logic [LINE_W-1:0] lines;
    } cfg_t;

    typedef struct packed {
        phase_t phase;
        seg_t   seg;
        logic   field_bit;
        logic   first;
    } timing_t;

    // Thresholds are ceil(255*k/6) for k = 1..6, so the count of thresholds
    // reached equals floor(6*luma/255).
    localparam logic [LUMA_W-1:0] LUMA_STEP1 = 8'd43;
    localparam logic [LUMA_W-1:0] LUMA_STEP2 = 8'd85;
    localparam logic [LUMA_W-1:0] LUMA_STEP3 = 8'd128;
    localparam logic [LUMA_W-1:0] LUMA_STEP4 = 8'd170;
    localparam logic [LUMA_W-1:0] LUMA_STEP5 = 8'd213;
    localparam logic [LUMA_W-1:0] LUMA_STEP6 = 8'd255;

    function automatic logic [LEVEL_W-1:0] luma_level(input logic [LUMA_W-1:0] luma);
        logic [LEVEL_W-1:0] lvl;
        lvl = 3'd1;
        lvl = lvl + {2'b00, (luma >= LUMA_STEP1)};
        lvl = lvl + {2'b00, (luma >= LUMA_STEP2)};
        lvl = lvl + {2'b00, (luma >= LUMA_STEP3)};
        lvl = lvl + {2'b00, (luma >= LUMA_STEP4)};
        lvl = lvl + {2'b00, (luma >= LUMA_STEP5)};
        lvl = lvl + {2'b00, (luma >= LUMA_STEP6)};
        return lvl;
    endfunction

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

### rtl/composite_video_sync_generator_top.sv
// Channel  Direction  Bits                 Contents
// s_       in         tdata[7:0]           luma
// m_       out        tdata[2:0], tuser    drive_level; pixel_taken, field_index, frame_start
// cfg_     in         index[2:0], wdata    timing register writes
//
// Each beat passes an input register and then a result register.
// One beat is accepted per cycle when the result side keeps taking beats.
// The result register frees in the cycle it is taken, so a new beat can move in as the old one leaves.
// The timing counters step once for each beat that moves into the result register.
// Reset restores the register defaults and starts at the first tick of field zero.
module composite_video_sync_generator_top #(
    parameter int unsigned ACTIVE_SAMPLES = 52,
    parameter int unsigned BROAD_PULSES = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] luma
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [2:0] drive_level, rest zero
    output logic [2:0]                          m_tuser,   // pixel_taken, field_index, frame_start
    input  logic                                cfg_wr_en,
    input  logic [cvsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cvsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import cvsg_pkg::*;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [LUMA_W-1:0]  luma_reg;
    logic               move;
    logic               out_valid;
    logic [LEVEL_W-1:0] drive_level;
    logic               pixel_taken;
    logic               field_index;
    logic               frame_start;
    timing_t            tm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_low   <= 6'd2;
            cfg_reg.short_high  <= 6'd30;
            cfg_reg.broad_low   <= 6'd30;
            cfg_reg.broad_high  <= 6'd2;
            cfg_reg.line_sync   <= 6'd4;
            cfg_reg.back_porch  <= 6'd6;
            cfg_reg.front_porch <= 6'd2;
            cfg_reg.lines       <= 9'd305;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_SHORT_LOW:   cfg_reg.short_low   <= cfg_wdata[TICK_W-1:0];
                REG_SHORT_HIGH:  cfg_reg.short_high  <= cfg_wdata[TICK_W-1:0];
                REG_BROAD_LOW:   cfg_reg.broad_low   <= cfg_wdata[TICK_W-1:0];
                REG_BROAD_HIGH:  cfg_reg.broad_high  <= cfg_wdata[TICK_W-1:0];
                REG_LINE_SYNC:   cfg_reg.line_sync   <= cfg_wdata[TICK_W-1:0];
                REG_BACK_PORCH:  cfg_reg.back_porch  <= cfg_wdata[TICK_W-1:0];
                REG_FRONT_PORCH: cfg_reg.front_porch <= cfg_wdata[TICK_W-1:0];
                REG_LINES:       cfg_reg.lines       <= cfg_wdata[LINE_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign move     = in_valid_reg && (!out_valid || m_tready);
    assign s_tready = !in_valid_reg || move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            luma_reg <= s_tdata;
        end
    end

    cvsg_timing #(
        .ACTIVE_SAMPLES (ACTIVE_SAMPLES),
        .BROAD_PULSES   (BROAD_PULSES)
    ) u_timing (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .advance (move),
        .tm      (tm)
    );

    cvsg_shaper u_shaper (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (move),
        .take        (m_tready),
        .luma        (luma_reg),
        .tm          (tm),
        .valid       (out_valid),
        .drive_level (drive_level),
        .pixel_taken (pixel_taken),
        .field_index (field_index),
        .frame_start (frame_start)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {5'b00000, drive_level};
    assign m_tuser  = {frame_start, field_index, pixel_taken};

endmodule

### rtl/cvsg_timing.sv
module cvsg_timing #(
    parameter int unsigned ACTIVE_SAMPLES = 52,
    parameter int unsigned BROAD_PULSES = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cvsg_pkg::cfg_t    cfg,
    input  logic              advance,
    output cvsg_pkg::timing_t tm
);
    import cvsg_pkg::*;

    phase_t              phase_reg, phase_next;
    seg_t                seg_reg, seg_next;
    logic                field_bit_reg, field_bit_next;
    logic [PULSE_W-1:0]  pulse_count_reg, pulse_count_next;
    logic [LINE_W-1:0]   line_count_reg, line_count_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;

    logic [TICK_W-1:0]   seg_len;
    logic [PULSE_W-1:0]  pulses;
    logic [LINE_W-1:0]   lines_eff;
    logic                tick_more;
    logic                pulse_more;
    logic                line_more;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PHASE_PRE_EQ;
            seg_reg         <= SEG_LOW;
            field_bit_reg   <= 1'b0;
            pulse_count_reg <= '0;
            line_count_reg  <= '0;
            tick_count_reg  <= '0;
        end else begin
            phase_reg       <= phase_next;
            seg_reg         <= seg_next;
            field_bit_reg   <= field_bit_next;
            pulse_count_reg <= pulse_count_next;
            line_count_reg  <= line_count_next;
            tick_count_reg  <= tick_count_next;
        end
    end

    always_comb begin
        case (phase_reg)
            PHASE_LINES: begin
                case (seg_reg)
                    SEG_LOW:    seg_len = at_least_one(cfg.line_sync);
                    SEG_HIGH:   seg_len = at_least_one(cfg.back_porch);
                    SEG_ACTIVE: seg_len = TICK_W'(ACTIVE_SAMPLES);
                    default:    seg_len = at_least_one(cfg.front_porch);
                endcase
            end
            PHASE_BROAD: begin
                seg_len = at_least_one((seg_reg == SEG_LOW) ? cfg.broad_low : cfg.broad_high);
            end
            default: begin
                seg_len = at_least_one((seg_reg == SEG_LOW) ? cfg.short_low : cfg.short_high);
            end
        endcase

        pulses = (phase_reg == PHASE_BROAD) ? PULSE_W'(BROAD_PULSES)
                                            : EQ_BASE_PULSES + {2'b00, field_bit_reg};

        if (cfg.lines == '0) begin
            lines_eff = LINE_W'(1);
        end else if (cfg.lines > MAX_LINES) begin
            lines_eff = MAX_LINES;
        end else begin
            lines_eff = cfg.lines;
        end

        tick_more  = ({1'b0, tick_count_reg} + 7'd1) < {1'b0, seg_len};
        pulse_more = ({1'b0, pulse_count_reg} + 4'd1) < {1'b0, pulses};
        line_more  = ({1'b0, line_count_reg} + 10'd1) < {1'b0, lines_eff};

        phase_next       = phase_reg;
        seg_next         = seg_reg;
        field_bit_next   = field_bit_reg;
        pulse_count_next = pulse_count_reg;
        line_count_next  = line_count_reg;
        tick_count_next  = tick_count_reg;

        if (advance) begin
            if (tick_more) begin
                tick_count_next = tick_count_reg + TICK_W'(1);
            end else begin
                tick_count_next = '0;
                case (phase_reg)
                    PHASE_LINES: begin
                        if (seg_reg != SEG_FRONT) begin
                            seg_next = seg_t'(seg_reg + 2'd1);
                        end else begin
                            seg_next = SEG_LOW;
                            if (line_more) begin
                                line_count_next = line_count_reg + LINE_W'(1);
                            end else begin
                                line_count_next  = '0;
                                pulse_count_next = '0;
                                phase_next       = PHASE_PRE_EQ;
                                field_bit_next   = ~field_bit_reg;
                            end
                        end
                    end
                    default: begin
                        if (seg_reg == SEG_LOW) begin
                            seg_next = SEG_HIGH;
                        end else begin
                            seg_next = SEG_LOW;
                            if (pulse_more) begin
                                pulse_count_next = pulse_count_reg + PULSE_W'(1);
                            end else begin
                                pulse_count_next = '0;
                                phase_next       = phase_t'(phase_reg + 2'd1);
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign tm.phase     = phase_reg;
    assign tm.seg       = seg_reg;
    assign tm.field_bit = field_bit_reg;
    assign tm.first     = !field_bit_reg && (phase_reg == PHASE_PRE_EQ) &&
                          (pulse_count_reg == '0) && (seg_reg == SEG_LOW) &&
                          (tick_count_reg == '0);

    a_lines_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_count_reg != '0) |-> (phase_reg == PHASE_LINES))
        else $error("Line count is nonzero outside the line phase.");

    a_pulse_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PHASE_LINES) |-> (pulse_count_reg == '0))
        else $error("Pulse count is nonzero during the line phase.");

    a_pulse_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PHASE_LINES) |-> (seg_reg == SEG_LOW || seg_reg == SEG_HIGH))
        else $error("Line segment code seen in a pulse phase.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(tick_count_reg) && $stable(phase_reg) && $stable(seg_reg)))
        else $error("Timing state moved without a beat.");

endmodule

### rtl/cvsg_shaper.sv
module cvsg_shaper (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic                            take,
    input  logic [cvsg_pkg::LUMA_W-1:0]     luma,
    input  cvsg_pkg::timing_t               tm,
    output logic                            valid,
    output logic [cvsg_pkg::LEVEL_W-1:0]    drive_level,
    output logic                            pixel_taken,
    output logic                            field_index,
    output logic                            frame_start
);
    import cvsg_pkg::*;

    logic                valid_reg;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                taken_reg, taken_next;
    logic                field_reg;
    logic                first_reg;

    always_comb begin
        taken_next = 1'b0;
        if (tm.phase == PHASE_LINES) begin
            case (tm.seg)
                SEG_LOW:    level_next = LEVEL_SYNC;
                SEG_ACTIVE: begin
                    level_next = luma_level(luma);
                    taken_next = 1'b1;
                end
                default:    level_next = LEVEL_BLANK;
            endcase
        end else begin
            level_next = (tm.seg == SEG_LOW) ? LEVEL_SYNC : LEVEL_BLANK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            level_reg <= level_next;
            taken_reg <= taken_next;
            field_reg <= tm.field_bit;
            first_reg <= tm.first;
        end
    end

    assign valid       = valid_reg;
    assign drive_level = level_reg;
    assign pixel_taken = taken_reg;
    assign field_index = field_reg;
    assign frame_start = first_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import cvsg_pkg::*;

    localparam int ACTIVE_SAMPLES = 52;
    localparam int BROAD_PULSES = 5;
    localparam int PHASE_TICKS = 100;
    localparam int CLAMP_TICKS = 100;
    localparam int LONG_STALL = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int N_EDGES = 14;

    // These luma values sit on both sides of each step of the level quantizer.
    localparam logic [LUMA_W-1:0] LUMA_EDGES [N_EDGES] = '{
        8'd0, 8'd1, 8'd42, 8'd43, 8'd84, 8'd85, 8'd127,
        8'd128, 8'd169, 8'd170, 8'd212, 8'd213, 8'd254, 8'd255
    };

    typedef enum int {
        SET_ZERO,
        SET_SHORT,
        SET_LONG,
        SET_MIXED,
        SET_CLAMP
    } setting_t;

    localparam setting_t PLAN [3][3] = '{
        '{SET_SHORT, SET_MIXED, SET_SHORT},
        '{SET_LONG, SET_SHORT, SET_MIXED},
        '{SET_SHORT, SET_MIXED, SET_CLAMP}
    };
    localparam int SEND_IDLE [3] = '{36, 78, 0};
    localparam int RECV_IDLE [3] = '{78, 36, 0};

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               taken;
        logic               field;
        logic               first;
    } drive_beat_t;

    class drive_level_scoreboard;
        logic [TICK_W-1:0] span [7];
        logic [LINE_W-1:0] lines_reg;
        logic              field_bit;
        phase_t            phase;
        seg_t              seg;
        logic [PULSE_W-1:0] pulse_cnt;
        logic [LINE_W-1:0] line_cnt;
        logic [TICK_W-1:0] tick_cnt;
        drive_beat_t       expected_beats [$];
        int                errors;

        function new();
            span[REG_SHORT_LOW] = 6'd2;
            span[REG_SHORT_HIGH] = 6'd30;
            span[REG_BROAD_LOW] = 6'd30;
            span[REG_BROAD_HIGH] = 6'd2;
            span[REG_LINE_SYNC] = 6'd4;
            span[REG_BACK_PORCH] = 6'd6;
            span[REG_FRONT_PORCH] = 6'd2;
            lines_reg = 9'd305;
            field_bit = 1'b0;
            phase = PHASE_PRE_EQ;
            seg = SEG_LOW;
            pulse_cnt = '0;
            line_cnt = '0;
            tick_cnt = '0;
            errors = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_LINES) begin
                lines_reg = value[LINE_W-1:0];
            end else begin
                span[idx] = value[TICK_W-1:0];
            end
        endfunction

        function int unsigned nonzero_ticks(logic [TICK_W-1:0] ticks);
            return (ticks == '0) ? 1 : ticks;
        endfunction

        function int unsigned seg_ticks();
            if (phase == PHASE_LINES) begin
                case (seg)
                    SEG_LOW:    return nonzero_ticks(span[REG_LINE_SYNC]);
                    SEG_HIGH:   return nonzero_ticks(span[REG_BACK_PORCH]);
                    SEG_ACTIVE: return ACTIVE_SAMPLES;
                    default:    return nonzero_ticks(span[REG_FRONT_PORCH]);
                endcase
            end
            if (phase == PHASE_BROAD) begin
                return nonzero_ticks(seg == SEG_LOW ? span[REG_BROAD_LOW] : span[REG_BROAD_HIGH]);
            end
            return nonzero_ticks(seg == SEG_LOW ? span[REG_SHORT_LOW] : span[REG_SHORT_HIGH]);
        endfunction

        // A segment, pulse train or line run ends once its count reaches the
        // current limit, so shrinking a register mid-segment ends it at once.
        function void step_timing();
            int unsigned pulses;
            int unsigned lines_eff;
            if (tick_cnt + 1 < seg_ticks()) begin
                tick_cnt++;
                return;
            end
            tick_cnt = '0;
            if (phase == PHASE_LINES) begin
                if (seg != SEG_FRONT) begin
                    seg = seg_t'(seg + 1);
                    return;
                end
                seg = SEG_LOW;
                lines_eff = (lines_reg == '0) ? 1 : lines_reg;
                if (lines_eff > MAX_LINES) begin
                    lines_eff = MAX_LINES;
                end
                if (line_cnt + 1 < lines_eff) begin
                    line_cnt++;
                    return;
                end
                line_cnt = '0;
                pulse_cnt = '0;
                phase = PHASE_PRE_EQ;
                field_bit = ~field_bit;
                return;
            end
            if (seg == SEG_LOW) begin
                seg = SEG_HIGH;
                return;
            end
            seg = SEG_LOW;
            pulses = (phase == PHASE_BROAD) ? BROAD_PULSES : EQ_BASE_PULSES + field_bit;
            if (pulse_cnt + 1 < pulses) begin
                pulse_cnt++;
                return;
            end
            pulse_cnt = '0;
            phase = phase_t'(phase + 1);
        endfunction

        function void note_tick(logic [LUMA_W-1:0] luma);
            drive_beat_t beat;
            int unsigned lum;
            lum = luma;
            beat.first = (field_bit == 1'b0 && phase == PHASE_PRE_EQ && pulse_cnt == '0 &&
                          seg == SEG_LOW && tick_cnt == '0);
            beat.field = field_bit;
            beat.taken = 1'b0;
            beat.level = (seg == SEG_LOW) ? LEVEL_SYNC : LEVEL_BLANK;
            if (phase == PHASE_LINES && seg == SEG_ACTIVE) begin
                beat.level = LEVEL_W'((6 * lum) / 255 + 1);
                beat.taken = 1'b1;
            end
            expected_beats.push_back(beat);
            step_timing();
        endfunction

        function void check_beat(logic [LEVEL_W-1:0] level, logic taken, logic field,
                                 logic first);
            drive_beat_t want;
            if (expected_beats.size() == 0) begin
                errors++;
                $error("Result beat arrived with no tick outstanding.");
                return;
            end
            want = expected_beats.pop_front();
            if (level !== want.level) begin
                errors++;
                $error("drive_level: expected %0d, actual %0d", want.level, level);
            end
            if (taken !== want.taken) begin
                errors++;
                $error("pixel_taken: expected %0d, actual %0d", want.taken, taken);
            end
            if (field !== want.field) begin
                errors++;
                $error("field_index: expected %0d, actual %0d", want.field, field);
            end
            if (first !== want.first) begin
                errors++;
                $error("frame_start: expected %0d, actual %0d", want.first, first);
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;
    logic [2:0]             m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    drive_level_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit stall_armed = 1'b0;
    bit stall_done = 1'b0;
    int idle_cycles = 0;

    composite_video_sync_generator_top #(
        .ACTIVE_SAMPLES (ACTIVE_SAMPLES),
        .BROAD_PULSES   (BROAD_PULSES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_tick(s_tdata[LUMA_W-1:0]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_beat(m_tdata[LEVEL_W-1:0], m_tuser[0], m_tuser[1], m_tuser[2]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("composite_video_sync_generator_top verification failed");
                $finish;
            end
        end
    end

    // The receiver holds off once for a long stretch so that the block fills up.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_armed && !stall_done) begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [LUMA_W-1:0] pick_luma();
        if ($urandom_range(1) == 0) begin
            return LUMA_EDGES[$urandom_range(N_EDGES - 1)];
        end
        return LUMA_W'($urandom_range(255));
    endfunction

    task automatic send_tick(input logic [LUMA_W-1:0] luma);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= luma;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(input setting_t kind);
        logic [CFG_DATA_W-1:0] value;
        logic [TICK_W-1:0]     ticks;
        for (int i = 0; i < 8; i++) begin
            case (kind)
                SET_ZERO:  ticks = '0;
                SET_SHORT: ticks = TICK_W'($urandom_range(3));
                SET_LONG:  ticks = 6'd63;
                SET_MIXED: ticks = ($urandom_range(4) == 0) ? 6'd63 : TICK_W'($urandom_range(3));
                default:   ticks = TICK_W'($urandom_range(1));
            endcase
            value = {3'($urandom), ticks};
            if (reg_index_t'(i) == REG_LINES) begin
                case (kind)
                    SET_ZERO:  value = '0;
                    SET_CLAMP: value = CFG_DATA_W'($urandom_range(511, 313));
                    default:   value = CFG_DATA_W'($urandom_range(4));
                endcase
            end
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_wdata <= value;
            sb.set_reg(reg_index_t'(i), value);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        setting_t kind;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With every duration at its minimum, active video starts on tick 32.
        apply_setting(SET_ZERO);
        for (int i = 0; i < 32; i++) begin
            send_tick(i[0] ? 8'hFF : 8'h00);
        end
        for (int i = 0; i < N_EDGES; i++) begin
            send_tick(LUMA_EDGES[i]);
        end
        s_tvalid <= 1'b0;
        wait_drain();

        for (int stage = 0; stage < 3; stage++) begin
            send_idle_pct = SEND_IDLE[stage];
            recv_idle_pct = RECV_IDLE[stage];
            for (int p = 0; p < 3; p++) begin
                kind = PLAN[stage][p];
                apply_setting(kind);
                if (stage == 2 && p == 0) begin
                    stall_armed = 1'b1;
                end
                repeat ((kind == SET_CLAMP) ? CLAMP_TICKS : PHASE_TICKS) send_tick(pick_luma());
                s_tvalid <= 1'b0;
                wait_drain();
            end
        end

        if (sb.errors == 0) begin
            $display("composite_video_sync_generator_top verification clean");
        end else begin
            $display("composite_video_sync_generator_top verification failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/cvsg_pkg.sv
rtl/cvsg_timing.sv
rtl/cvsg_shaper.sv
rtl/composite_video_sync_generator_top.sv
tb/tb_top.sv
